// File: sv/sac_pkg.sv
// Shared types, codes and helpers for the set-associative cache tag model.
`timescale 1ns / 1ps
package sac_pkg;

	localparam int ADDR_W = 64;
	localparam int TAG_W  = 62;
	localparam int CNT_W  = 32;

	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_STORE  = 2'd1;
	localparam logic [1:0] OP_MODIFY = 2'd2;

	localparam logic [1:0] CFG_SET_BITS    = 2'd0;
	localparam logic [1:0] CFG_WAYS        = 2'd1;
	localparam logic [1:0] CFG_OFFSET_BITS = 2'd2;

	typedef struct packed {
		logic             was_hit;
		logic             was_eviction;
		logic [CNT_W-1:0] hits_so_far;
		logic [CNT_W-1:0] misses_so_far;
		logic [CNT_W-1:0] evictions_so_far;
		logic             last_of_item;
	} sac_result_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		sat_inc = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
	endfunction

endpackage

// File: sv/sac_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module sac_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// File: sv/sac_front.sv
// Front end: accepts accesses and splits the address into set and tag.
`timescale 1ns / 1ps
module sac_front #(
	parameter int MAX_SET_BITS = 6
) (
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 operation,
	input  logic [63:0]                address,
	input  logic [2:0]                 set_bits_cfg,
	input  logic [5:0]                 offset_bits_cfg,
	input  logic                       q_full,
	output logic                       push,
	output logic [MAX_SET_BITS-1:0]    push_set,
	output logic [sac_pkg::TAG_W-1:0]  push_tag,
	output logic                       push_dual
);
	import sac_pkg::*;

	logic [2:0]              sb;
	logic [5:0]              bb;
	logic [6:0]              amt;
	logic [ADDR_W-1:0]       shifted;
	logic [ADDR_W-1:0]       tag_full;
	logic [MAX_SET_BITS-1:0] mask;

	always_comb begin
		sb = (int'(set_bits_cfg) > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : set_bits_cfg;
		if (sb == 3'd0) begin
			sb = 3'd1;
		end
		bb = (offset_bits_cfg == 6'd0) ? 6'd1 : offset_bits_cfg;
		for (int i = 0; i < MAX_SET_BITS; i++) begin
			mask[i] = (i < int'(sb));
		end
		shifted  = address >> bb;
		amt      = {4'd0, sb} + {1'b0, bb};
		tag_full = amt[6] ? '0 : (address >> amt[5:0]);
	end

	assign push_set  = shifted[MAX_SET_BITS-1:0] & mask;
	assign push_tag  = tag_full[TAG_W-1:0];
	assign push_dual = (operation == OP_MODIFY);
	assign push      = in_valid && !q_full;
	assign in_stall  = q_full;
endmodule

// File: sv/sac_queue.sv
// Two-entry queue between the front end and the set update engine.
`timescale 1ns / 1ps
module sac_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             full,
	output logic             empty
);
	logic [WIDTH-1:0] ent_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	assign dout  = ent_q[rd_ptr_q];
	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
endmodule

// File: sv/sac_back.sv
// Back end: read-modify-write of one set row per access, LRU update, totals.
`timescale 1ns / 1ps
module sac_back #(
	parameter int MAX_SET_BITS = 6,
	parameter int MAX_WAYS     = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_valid,
	input  logic [MAX_SET_BITS-1:0]    q_set,
	input  logic [sac_pkg::TAG_W-1:0]  q_tag,
	input  logic                       q_dual,
	output logic                       q_pop,
	input  logic [MAX_WAYS-1:0]        way_en,
	output logic                       out_valid,
	input  logic                       out_stall,
	output sac_pkg::sac_result_t       out_res
);
	import sac_pkg::*;

	localparam int SETS  = 1 << MAX_SET_BITS;
	localparam int RW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int IW    = RW;
	localparam int ROW_W = MAX_WAYS * (1 + RW + TAG_W);
	localparam int RK_LO = MAX_WAYS;
	localparam int TG_LO = MAX_WAYS * (1 + RW);
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_UPD  = 1'b1;

	logic             st_q;
	logic             second_q;
	logic             row_ok_q;
	logic [SETS-1:0]  row_written_q;
	logic [CNT_W-1:0] hit_cnt_q;
	logic [CNT_W-1:0] miss_cnt_q;
	logic [CNT_W-1:0] evict_cnt_q;
	logic             out_valid_q;
	sac_result_t      out_q;

	logic [ROW_W-1:0] row_rd;
	logic [ROW_W-1:0] row_wr;
	logic             rd_en;
	logic             fire;
	logic             last_acc;

	logic [MAX_WAYS-1:0] vld, hitv, empv, new_vld;
	logic [RW-1:0]       rk [MAX_WAYS];
	logic [RW-1:0]       new_rk [MAX_WAYS];
	logic [TAG_W-1:0]    tg [MAX_WAYS];
	logic [IW-1:0]       hit_idx, emp_idx, vic_idx, tgt;
	logic                any_hit, any_emp, t_valid, evict;
	logic [RW-1:0]       t_rank;

	sac_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_rows (
		.clk   (clk),
		.we    (fire),
		.waddr (q_set),
		.wdata (row_wr),
		.re    (rd_en),
		.raddr (q_set),
		.rdata (row_rd)
	);

	always_comb begin
		for (int i = 0; i < MAX_WAYS; i++) begin
			vld[i]  = row_ok_q & row_rd[i];
			rk[i]   = row_ok_q ? row_rd[RK_LO + i*RW +: RW] : '0;
			tg[i]   = row_rd[TG_LO + i*TAG_W +: TAG_W];
			hitv[i] = way_en[i] && vld[i] && (tg[i] == q_tag);
			empv[i] = way_en[i] && !vld[i];
		end
		any_hit = |hitv;
		any_emp = |empv;
		hit_idx = '0;
		emp_idx = '0;
		for (int i = MAX_WAYS - 1; i >= 0; i--) begin
			if (hitv[i]) begin
				hit_idx = IW'(i);
			end
			if (empv[i]) begin
				emp_idx = IW'(i);
			end
		end
		// oldest way, lowest index wins a tie
		vic_idx = '0;
		for (int i = 1; i < MAX_WAYS; i++) begin
			if (way_en[i] && (rk[i] > rk[vic_idx])) begin
				vic_idx = IW'(i);
			end
		end
		tgt     = any_hit ? hit_idx : (any_emp ? emp_idx : vic_idx);
		evict   = !any_hit && !any_emp;
		t_valid = vld[tgt];
		t_rank  = rk[tgt];
		for (int i = 0; i < MAX_WAYS; i++) begin
			new_vld[i] = vld[i];
			new_rk[i]  = rk[i];
			if (IW'(i) == tgt) begin
				new_vld[i] = 1'b1;
				new_rk[i]  = '0;
			end else if (way_en[i] && vld[i] && (!t_valid || (rk[i] < t_rank)) &&
				(rk[i] < RW'(MAX_WAYS - 1))) begin
				new_rk[i] = rk[i] + RW'(1);
			end
		end
		for (int i = 0; i < MAX_WAYS; i++) begin
			row_wr[i]                  = new_vld[i];
			row_wr[RK_LO + i*RW +: RW] = new_rk[i];
			row_wr[TG_LO + i*TAG_W +: TAG_W] = (IW'(i) == tgt) ? q_tag : tg[i];
		end
	end

	assign rd_en    = (st_q == ST_IDLE) && q_valid;
	assign fire     = (st_q == ST_UPD) && (!out_valid_q || !out_stall);
	assign last_acc = !q_dual || second_q;
	assign q_pop    = fire && last_acc;

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q.was_hit          <= any_hit;
			out_q.was_eviction     <= evict;
			out_q.hits_so_far      <= any_hit ? sat_inc(hit_cnt_q) : hit_cnt_q;
			out_q.misses_so_far    <= any_hit ? miss_cnt_q : sat_inc(miss_cnt_q);
			out_q.evictions_so_far <= evict ? sat_inc(evict_cnt_q) : evict_cnt_q;
			out_q.last_of_item     <= last_acc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q          <= ST_IDLE;
			second_q      <= 1'b0;
			row_ok_q      <= 1'b0;
			row_written_q <= '0;
			hit_cnt_q     <= '0;
			miss_cnt_q    <= '0;
			evict_cnt_q   <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			// a new result replaces the held one; otherwise drop it once taken
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (q_valid) begin
						row_ok_q <= row_written_q[q_set];
						st_q     <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (fire) begin
						row_written_q[q_set] <= 1'b1;
						if (any_hit) begin
							hit_cnt_q <= sat_inc(hit_cnt_q);
						end else begin
							miss_cnt_q <= sat_inc(miss_cnt_q);
						end
						if (evict) begin
							evict_cnt_q <= sat_inc(evict_cnt_q);
						end
						second_q <= !last_acc;
						st_q     <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;
endmodule

// File: sv/set_assoc_lru_cache_tag_sim_top.sv
// Top level of the set-associative cache tag model with true LRU replacement.
// Usage:
//   Input channel (in_valid / in_stall) carries one access per item: operation
//   (load, store, modify; code 3 acts as a load) and a 64-bit byte address.
//   Output channel (out_valid / out_stall) carries one result per access; a
//   modify item gives two results, last_of_item marks the final one.
//   Configuration (cfg_we, cfg_index, cfg_data) sets set bits, ways in use and
//   block offset bits; write only while idle. Stored lines survive rewrites.
// Timing:
//   Each access is a read then a write of its set row in one RAM port pair:
//   the row is read in the idle state and written back in the update state,
//   and the result is registered. A modify item makes two such accesses.
//   A two-entry queue lets the front keep taking items while the back works.
// Reset:
//   arst_n clears the totals, the queue and the per-set written flags, so all
//   lines read as empty with rank 0; configuration returns to 1/1/1.
//   No clearing pass is needed; items are taken right after reset.
// Stall:
//   A held result stays put while out_stall is high; the back end waits with
//   the set data held, the queue fills and then in_stall rises.
`timescale 1ns / 1ps
module set_assoc_lru_cache_tag_sim_top #(
	parameter int MAX_SET_BITS = 6,
	parameter int MAX_WAYS     = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [5:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [63:0] address,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        was_hit,
	output logic        was_eviction,
	output logic [31:0] hits_so_far,
	output logic [31:0] misses_so_far,
	output logic [31:0] evictions_so_far,
	output logic        last_of_item
);
	import sac_pkg::*;

	localparam int ENT_W = MAX_SET_BITS + TAG_W + 1;

	// configuration registers
	logic [2:0] set_bits_q;
	logic [3:0] ways_q;
	logic [5:0] offset_bits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q    <= 3'd1;
			ways_q        <= 4'd1;
			offset_bits_q <= 6'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SET_BITS:    set_bits_q    <= cfg_data[2:0];
				CFG_WAYS:        ways_q        <= cfg_data[3:0];
				CFG_OFFSET_BITS: offset_bits_q <= cfg_data;
				default:         ;
			endcase
		end
	end

	// ways searched: clamp to 1..MAX_WAYS, then a thermometer enable
	logic [4:0]          ways_eff;
	logic [MAX_WAYS-1:0] way_en;

	always_comb begin
		ways_eff = {1'b0, ways_q};
		if (ways_eff == 5'd0) begin
			ways_eff = 5'd1;
		end
		if (int'(ways_eff) > MAX_WAYS) begin
			ways_eff = 5'(MAX_WAYS);
		end
		for (int i = 0; i < MAX_WAYS; i++) begin
			way_en[i] = (i < int'(ways_eff));
		end
	end

	// front end
	logic                    push, pop, q_full, q_empty;
	logic [MAX_SET_BITS-1:0] push_set;
	logic [TAG_W-1:0]        push_tag;
	logic                    push_dual;
	logic [ENT_W-1:0]        q_dout;

	sac_front #(.MAX_SET_BITS(MAX_SET_BITS)) u_front (
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.operation       (operation),
		.address         (address),
		.set_bits_cfg    (set_bits_q),
		.offset_bits_cfg (offset_bits_q),
		.q_full          (q_full),
		.push            (push),
		.push_set        (push_set),
		.push_tag        (push_tag),
		.push_dual       (push_dual)
	);

	sac_queue #(.WIDTH(ENT_W)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    ({push_dual, push_tag, push_set}),
		.pop    (pop),
		.dout   (q_dout),
		.full   (q_full),
		.empty  (q_empty)
	);

	// back end
	sac_result_t res;

	sac_back #(.MAX_SET_BITS(MAX_SET_BITS), .MAX_WAYS(MAX_WAYS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (!q_empty),
		.q_set     (q_dout[MAX_SET_BITS-1:0]),
		.q_tag     (q_dout[MAX_SET_BITS +: TAG_W]),
		.q_dual    (q_dout[ENT_W-1]),
		.q_pop     (pop),
		.way_en    (way_en),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (res)
	);

	assign was_hit          = res.was_hit;
	assign was_eviction     = res.was_eviction;
	assign hits_so_far      = res.hits_so_far;
	assign misses_so_far    = res.misses_so_far;
	assign evictions_so_far = res.evictions_so_far;
	assign last_of_item     = res.last_of_item;

`ifndef SYNTHESIS
	a_queue_state: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_full && q_empty))
		else $error("queue both full and empty");
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(was_hit && was_eviction))
		else $error("result is both hit and eviction");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty)
		else $error("pop from empty queue");
	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> in_stall)
		else $error("input taken while queue full");
`endif
endmodule
